[hdl/sa_pkg.sv]
// Shared types, codes and arithmetic helpers for the sparse accumulator.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package sa_pkg;

	localparam int VAL_W = 32;
	localparam int THR_W = 31;
	localparam int OP_W = 3;
	localparam int IN_IDX_W = 10;
	localparam int IDX_W = 6;
	localparam int COUNT_W = 7;

	// operation codes on the input channel
	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAN = 3'd2;
	localparam logic [OP_W-1:0] OP_DRAIN = 3'd3;
	localparam logic [OP_W-1:0] OP_SCALE = 3'd4;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_PRESENT = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		K_ADD,
		K_INSERT,
		K_CLEAN,
		K_DRAIN,
		K_SCALE,
		K_NOP
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RMW,
		S_LRD,
		S_VRD,
		S_WORK,
		S_WB,
		S_FIN
	} state_t;

	// one classified item as it sits in the queue
	typedef struct packed {
		kind_t kind;
		logic oor;
		logic [IDX_W-1:0] idx;
		logic signed [VAL_W-1:0] value;
		logic [THR_W-1:0] tol;
		logic signed [VAL_W-1:0] fac;
	} item_t;

	// magnitude at 33 bits so that the most negative value is exact
	function automatic logic [VAL_W:0] mag33(input logic signed [VAL_W:0] v);
		return v[VAL_W] ? (-v) : v;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat33(input logic signed [VAL_W:0] v);
		logic signed [VAL_W-1:0] r;
		if (v[VAL_W] != v[VAL_W-1]) begin
			r = v[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat48(input logic signed [47:0] v);
		logic signed [VAL_W-1:0] r;
		if (v[47:31] == '0 || v[47:31] == '1) begin
			r = v[VAL_W-1:0];
		end else begin
			r = v[47] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/sa_front.sv]
// Front end: takes input transfers, classifies them and queues them.
// Depends on sa_pkg for the item type and operation codes.
`default_nettype none
module sa_front #(
	parameter int CAPACITY = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [2:0] operation,
	input  wire logic [9:0] index,
	input  wire logic signed [31:0] value,
	input  wire logic [30:0] tolerance,
	input  wire logic signed [31:0] factor,
	output logic q_valid,
	output sa_pkg::item_t q_item,
	input  wire logic q_ready
);
	import sa_pkg::*;

	item_t slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	item_t cls;
	logic push, pop;

	// classify the incoming item
	always_comb begin
		case (operation)
			OP_ADD: cls.kind = K_ADD;
			OP_INSERT: cls.kind = K_INSERT;
			OP_CLEAN: cls.kind = K_CLEAN;
			OP_DRAIN: cls.kind = K_DRAIN;
			OP_SCALE: cls.kind = K_SCALE;
			default: cls.kind = K_NOP;
		endcase
		cls.oor = (index >= IN_IDX_W'(CAPACITY));
		cls.idx = index[IDX_W-1:0];
		cls.value = value;
		cls.tol = tolerance;
		cls.fac = factor;
	end

	assign in_ready = (fill_q != 2'd2);
	assign q_valid = (fill_q != 2'd0);
	assign q_item = slot_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

[hdl/sa_back.sv]
// Back end: sequencer that executes queued items on the value store,
// present bits and index list, and drives the result register. Uses sa_pkg.
`default_nettype none
module sa_back #(
	parameter int CAPACITY = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [30:0] tiny,
	input  wire logic q_valid,
	input  wire sa_pkg::item_t q_item,
	output logic q_ready,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [1:0] status,
	output logic [5:0] out_index,
	output logic signed [31:0] out_value,
	output logic [6:0] count,
	output logic last
);
	import sa_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;
	item_t cur_q;
	logic [CW-1:0] i_q, n_q, live_q;
	logic [CAPACITY-1:0] pres_q;
	logic [AW-1:0] ent_q;
	logic signed [VAL_W-1:0] vrd_q;
	logic vpres_q;
	logic [AW-1:0] lrd_q;
	logic signed [63:0] prod_s1;

	logic signed [VAL_W-1:0] val_mem [CAPACITY];
	logic [AW-1:0] list_mem [CAPACITY];

	// control produced by the output block
	logic v_re, v_we, l_re, l_we;
	logic [AW-1:0] v_ra, v_wa, l_ra, l_wa;
	logic signed [VAL_W-1:0] v_wd;
	logic [AW-1:0] l_wd;
	logic emit, e_last;
	status_t e_status;
	logic [IDX_W-1:0] e_index;
	logic signed [VAL_W-1:0] e_value;
	logic [CW-1:0] e_count;
	logic set_pres, clr_pres, live_inc, live_clr, live_ld_n, i_inc, n_inc, start;
	logic [AW-1:0] pres_a;

	logic ofree, in_walk, is_last;
	logic [AW-1:0] cidx;
	logic signed [VAL_W-1:0] wv, st, nv;
	logic signed [VAL_W:0] sum;
	logic keep;

	assign ofree = !out_valid || out_ready;
	assign cidx = cur_q.idx[AW-1:0];
	assign wv = vpres_q ? vrd_q : '0;
	assign sum = {wv[VAL_W-1], wv} + {cur_q.value[VAL_W-1], cur_q.value};
	assign st = sat33(sum);
	assign in_walk = (i_q < live_q);
	assign is_last = ((i_q + CW'(1)) == live_q);
	assign keep = (mag33({wv[VAL_W-1], wv}) >= {2'b00, cur_q.tol});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					case (q_item.kind)
						K_ADD, K_INSERT: state_d = S_RMW;
						K_CLEAN, K_SCALE: state_d = S_LRD;
						K_DRAIN: state_d = (live_q == '0) ? S_FIN : S_LRD;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_RMW: if (ofree) state_d = S_IDLE;
			S_LRD: state_d = in_walk ? S_VRD : S_FIN;
			S_VRD: state_d = S_WORK;
			S_WORK: begin
				case (cur_q.kind)
					K_SCALE: state_d = S_WB;
					K_DRAIN: if (ofree) state_d = is_last ? S_IDLE : S_LRD;
					default: state_d = S_LRD;
				endcase
			end
			S_WB: state_d = S_LRD;
			S_FIN: if (ofree) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_ready = 1'b0;
		v_re = 1'b0; v_ra = cidx;
		v_we = 1'b0; v_wa = cidx; v_wd = cur_q.value;
		l_re = 1'b0; l_ra = i_q[AW-1:0];
		l_we = 1'b0; l_wa = live_q[AW-1:0]; l_wd = cidx;
		emit = 1'b0; e_status = ST_OK; e_index = '0; e_value = '0;
		e_count = live_q; e_last = 1'b1;
		set_pres = 1'b0; clr_pres = 1'b0; pres_a = cidx;
		live_inc = 1'b0; live_clr = 1'b0; live_ld_n = 1'b0;
		i_inc = 1'b0; n_inc = 1'b0; start = 1'b0;
		nv = '0;
		case (state_q)
			S_IDLE: begin
				q_ready = 1'b1;
				start = q_valid;
				v_re = q_valid;
				v_ra = q_item.idx[AW-1:0];
			end
			S_RMW: begin
				emit = ofree;
				e_index = IDX_W'(cidx);
				if (cur_q.oor) begin
					e_status = ST_RANGE;
					e_index = '0;
				end else if (vpres_q && cur_q.kind == K_INSERT) begin
					e_status = ST_PRESENT;
					e_value = wv;
				end else if (vpres_q) begin
					// accumulate; a tiny sum stays listed at zero
					nv = (mag33({st[VAL_W-1], st}) >= {2'b00, tiny}) ? st : '0;
					v_we = ofree;
					v_wd = nv;
					e_value = nv;
				end else if ((cur_q.kind == K_INSERT ||
						mag33({cur_q.value[VAL_W-1], cur_q.value}) >= {2'b00, tiny}) &&
						live_q < CW'(CAPACITY)) begin
					// new entry appended to the list
					v_we = ofree;
					l_we = ofree;
					set_pres = ofree;
					live_inc = ofree;
					e_value = cur_q.value;
					e_count = live_q + CW'(1);
				end
			end
			S_LRD: begin
				l_re = in_walk;
				live_ld_n = !in_walk && (cur_q.kind == K_CLEAN);
			end
			S_VRD: begin
				v_re = 1'b1;
				v_ra = lrd_q;
			end
			S_WORK: begin
				pres_a = ent_q;
				case (cur_q.kind)
					K_CLEAN: begin
						i_inc = 1'b1;
						if (keep) begin
							l_we = 1'b1;
							l_wa = n_q[AW-1:0];
							l_wd = ent_q;
							n_inc = 1'b1;
						end else begin
							clr_pres = 1'b1;
						end
					end
					K_DRAIN: begin
						emit = ofree;
						e_index = IDX_W'(ent_q);
						e_value = wv;
						e_count = '0;
						e_last = is_last;
						clr_pres = ofree;
						i_inc = ofree;
						live_clr = ofree && is_last;
					end
					default: ;
				endcase
			end
			S_WB: begin
				v_we = 1'b1;
				v_wa = ent_q;
				v_wd = sat48(prod_s1[63:16]);
				i_inc = 1'b1;
			end
			S_FIN: begin
				emit = ofree;
				e_status = (cur_q.kind == K_DRAIN) ? ST_EMPTY : ST_OK;
			end
			default: ;
		endcase
	end

	// value store and index list, registered reads
	always_ff @(posedge clk) begin
		if (v_we) val_mem[v_wa] <= v_wd;
		if (v_re) begin
			vrd_q <= val_mem[v_ra];
			vpres_q <= pres_q[v_ra];
		end
		if (l_we) list_mem[l_wa] <= l_wd;
		if (l_re) lrd_q <= list_mem[l_ra];
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		if (start) cur_q <= q_item;
		if (state_q == S_VRD) ent_q <= lrd_q;
		if (state_q == S_WORK) prod_s1 <= wv * cur_q.fac;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			n_q <= '0;
			live_q <= '0;
			pres_q <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				i_q <= '0;
				n_q <= '0;
			end else begin
				if (i_inc) i_q <= i_q + CW'(1);
				if (n_inc) n_q <= n_q + CW'(1);
			end
			if (live_inc) live_q <= live_q + CW'(1);
			else if (live_clr) live_q <= '0;
			else if (live_ld_n) live_q <= n_q;
			if (set_pres) pres_q[pres_a] <= 1'b1;
			else if (clr_pres) pres_q[pres_a] <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status <= e_status;
			out_index <= e_index;
			out_value <= e_value;
			count <= COUNT_W'(e_count);
			last <= e_last;
		end
	end

endmodule
`default_nettype wire

[hdl/sparse_accumulator_unit.sv]
// Top level of the sparse accumulator: threshold register, front end, queue
// and back-end sequencer. Depends on sa_pkg, sa_front and sa_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  input    | in_valid / in_ready     | operation index value tolerance factor
//  result   | out_valid / out_ready   | status out_index out_value count last
//  config   | cfg_we (no wait)        | cfg_data (tiny threshold)
//
// Add, insert: queue pop, then read-modify-write of the value store. Empty
// drain and other codes: pop, then result. Clean, scale, drain: pop, then per
// listed entry a list read, value read, and keep check (clean), multiply, write
// back (scale) or result (drain); clean, scale end: end-of-list check, result.
// A two-entry queue between front and back lets input transfers land while
// the back end works; a result waiting for out_ready stalls the next result.
// Reset clears the present bits and counters at once; no clearing pass.
`default_nettype none
module sparse_accumulator_unit #(
	parameter int CAPACITY = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [30:0] cfg_data,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [2:0] operation,
	input  wire logic [9:0] index,
	input  wire logic signed [31:0] value,
	input  wire logic [30:0] tolerance,
	input  wire logic signed [31:0] factor,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [1:0] status,
	output logic [5:0] out_index,
	output logic signed [31:0] out_value,
	output logic [6:0] count,
	output logic last
);
	import sa_pkg::*;

	logic [THR_W-1:0] tiny_q;
	logic q_valid, q_ready;
	item_t q_item;

	// tiny threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiny_q <= THR_W'(1);
		end else if (cfg_we) begin
			tiny_q <= cfg_data;
		end
	end

	sa_front #(.CAPACITY(CAPACITY)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .index(index), .value(value),
		.tolerance(tolerance), .factor(factor),
		.q_valid(q_valid), .q_item(q_item), .q_ready(q_ready)
	);

	sa_back #(.CAPACITY(CAPACITY)) u_back (
		.clk(clk), .arst_n(arst_n), .tiny(tiny_q),
		.q_valid(q_valid), .q_item(q_item), .q_ready(q_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .out_index(out_index), .out_value(out_value),
		.count(count), .last(last)
	);

endmodule
`default_nettype wire

[hdl/sa_checker.sv]
// Port-level checks on the sparse accumulator results, bound to the top.
// Depends on sa_pkg for the status codes.
`default_nettype none
module sa_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] status,
	input wire logic [6:0] count,
	input wire logic signed [31:0] out_value,
	input wire logic last
);
	import sa_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(last))
		else $error("result changed while stalled");

	// reset leaves no result pending
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// only drain produces non-final results, and those are ok with count zero
	a_nonfinal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == ST_OK && count == 7'd0)
		else $error("bad non-final result");

	// an empty drain reports an empty list
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> count == 7'd0 && last && out_value == 32'sd0)
		else $error("bad empty drain result");

endmodule

bind sparse_accumulator_unit sa_checker u_sa_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.status(status), .count(count), .out_value(out_value), .last(last)
);
`default_nettype wire
